### hdl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants and types of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int CHANNEL_FRAC_BITS_DEF = 12;
  localparam int HUE_FRAC_BITS_DEF     = 7;

  localparam int HUE_W           = 16;
  localparam int SECTOR_DEG      = 60;
  localparam int FULL_CIRCLE_DEG = 360;

  // hue split stages, then total pipeline depth
  localparam int HUE_STAGES = 4;
  localparam int NUM_STAGES = 7;

  typedef logic [NUM_STAGES-1:0] stage_vec_t;
  typedef logic [HUE_STAGES-1:0] hue_vec_t;

endpackage

### hdl/hsv2rgb_ctrl.sv
// ----------------------------------------------------------------------------
// hsv2rgb_ctrl
// Valid tracking and per-stage load enables; empty stages fill while the
// output is stalled.
// ----------------------------------------------------------------------------
module hsv2rgb_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    hsv_valid,
  output logic                    hsv_ready,
  output logic                    rgb_valid,
  input  logic                    rgb_ready,
  output hsv2rgb_pkg::stage_vec_t load
);

  localparam int N = hsv2rgb_pkg::NUM_STAGES;

  hsv2rgb_pkg::stage_vec_t valid;
  hsv2rgb_pkg::stage_vec_t valid_next;

  always_comb begin
    load[N-1] = !valid[N-1] || rgb_ready;
    for (int i = N - 2; i >= 0; i--) begin
      load[i] = !valid[i] || load[i+1];
    end
    valid_next[0] = load[0] ? hsv_valid : valid[0];
    for (int i = 1; i < N; i++) begin
      valid_next[i] = load[i] ? valid[i-1] : valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign hsv_ready = load[0];
  assign rgb_valid = valid[N-1];

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv_ready |=> valid[0])
    else $error("accepted request did not enter first stage");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !hsv_ready |-> &valid)
    else $error("input blocked while pipeline has a bubble");

  generate
    for (genvar i = 0; i < N; i++) begin : g_hold
      a_stage_hold: assert property (@(posedge clk) disable iff (rst)
        valid[i] && !load[i] |=> valid[i])
        else $error("stalled stage lost its request");
    end
  endgenerate

endmodule

### hdl/hsv2rgb_hue.sv
// ----------------------------------------------------------------------------
// hsv2rgb_hue
// Splits hue into sector and in-sector fraction: two divide-by-60 steps,
// each a reciprocal multiply followed by a one-step correction.
// ----------------------------------------------------------------------------
module hsv2rgb_hue #(
  parameter int CHANNEL_FRAC_BITS = hsv2rgb_pkg::CHANNEL_FRAC_BITS_DEF,
  parameter int HUE_FRAC_BITS     = hsv2rgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  hsv2rgb_pkg::hue_vec_t                   load,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]           hue,
  output logic [hsv2rgb_pkg::HUE_W-HUE_FRAC_BITS-6:0] sector,
  output logic [CHANNEL_FRAC_BITS-1:0]            frac
);

  localparam int CF   = CHANNEL_FRAC_BITS;
  localparam int HF   = HUE_FRAC_BITS;
  localparam int HW   = hsv2rgb_pkg::HUE_W;
  localparam int HDW  = HW - HF;
  localparam int SECW = HDW - 5;
  localparam int YW   = CF + 6;
  localparam int M1W  = HDW - 5;
  localparam int M2W  = YW - 5;
  localparam logic [M1W-1:0] M1 =
    M1W'((64'd1 << HDW) / 64'(hsv2rgb_pkg::SECTOR_DEG));
  localparam logic [M2W-1:0] M2 =
    M2W'((64'd1 << YW) / 64'(hsv2rgb_pkg::SECTOR_DEG));
  localparam logic [31:0] FULL_HUE = 32'(hsv2rgb_pkg::FULL_CIRCLE_DEG) << HF;
  localparam logic [HDW-1:0] DEG60 = HDW'(hsv2rgb_pkg::SECTOR_DEG);
  localparam logic [YW-1:0]  Y60   = YW'(hsv2rgb_pkg::SECTOR_DEG);

  // stage 0
  logic [HW-1:0]    hue_w;
  logic [2*HDW-1:0] prod1;
  logic [HDW-1:0]   deg0;
  logic [HF-1:0]    hfrac0;
  logic [SECW-1:0]  est0;

  // stage 1
  logic [HDW-1:0]       rd;
  logic                 rd_ge;
  logic [5:0]           rdeg;
  logic [6+HF+CF-1:0]   wide;
  logic [SECW-1:0]      sector1;
  logic [YW-1:0]        y1;

  // stage 2
  logic [2*YW-1:0] prod2;
  logic [SECW-1:0] sector2;
  logic [YW-1:0]   y2;
  logic [CF-1:0]   fest2;

  // stage 3
  logic [YW-1:0] r2;
  logic          r2_ge;

  always_comb begin
    hue_w = (32'(hue) == FULL_HUE) ? '0 : hue;
    prod1 = (2*HDW)'(hue_w[HW-1:HF]) * (2*HDW)'(M1);
    rd    = deg0 - HDW'(est0) * DEG60;
    rd_ge = rd >= DEG60;
    rdeg  = rd_ge ? 6'(rd - DEG60) : 6'(rd);
    wide  = {rdeg, hfrac0, CF'(0)};
    prod2 = (2*YW)'(y1) * (2*YW)'(M2);
    r2    = y2 - YW'(fest2) * Y60;
    r2_ge = r2 >= Y60;
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      deg0   <= hue_w[HW-1:HF];
      hfrac0 <= hue_w[HF-1:0];
      est0   <= prod1[HDW +: SECW];
    end
    if (load[1]) begin
      sector1 <= est0 + SECW'(rd_ge);
      y1      <= wide[HF +: YW];
    end
    if (load[2]) begin
      sector2 <= sector1;
      y2      <= y1;
      fest2   <= prod2[YW +: CF];
    end
    if (load[3]) begin
      sector <= sector2;
      frac   <= fest2 + CF'(r2_ge);
    end
  end

endmodule

### hdl/hsv2rgb_mix.sv
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// Saturation clip, p/q/t scaling and per-sector channel select.
// ----------------------------------------------------------------------------
module hsv2rgb_mix #(
  parameter int CHANNEL_FRAC_BITS = hsv2rgb_pkg::CHANNEL_FRAC_BITS_DEF,
  parameter int HUE_FRAC_BITS     = hsv2rgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  hsv2rgb_pkg::stage_vec_t                     load,
  input  logic signed [CHANNEL_FRAC_BITS+1:0]         saturation,
  input  logic [CHANNEL_FRAC_BITS:0]                  brightness,
  input  logic [hsv2rgb_pkg::HUE_W-HUE_FRAC_BITS-6:0] sector,
  input  logic [CHANNEL_FRAC_BITS-1:0]                frac,
  output logic [CHANNEL_FRAC_BITS:0]                  red,
  output logic [CHANNEL_FRAC_BITS:0]                  green,
  output logic [CHANNEL_FRAC_BITS:0]                  blue
);

  localparam int CF   = CHANNEL_FRAC_BITS;
  localparam int CW   = CF + 1;
  localparam int SW   = CF + 2;
  localparam int SECW = hsv2rgb_pkg::HUE_W - HUE_FRAC_BITS - 5;
  localparam int HS   = hsv2rgb_pkg::HUE_STAGES;
  localparam logic [CW-1:0] ONE = CW'(1) << CF;

  logic [CW-1:0] sat_clip;
  logic [CW-1:0] sat_d [HS];
  logic [CW-1:0] val_d [HS];

  logic [2*CW-1:0] sf_prod, sg_prod, p_prod, q_prod, t_prod;

  logic [CW-1:0]   sf4, sg4, p4, val4;
  logic            grey4;
  logic [SECW-1:0] sec4;

  logic [CW-1:0]   q5, t5, p5, val5;
  logic            grey5;
  logic [SECW-1:0] sec5;

  logic [CW-1:0] red_next, green_next, blue_next;

  always_comb begin
    if (saturation[SW-1]) begin
      sat_clip = '0;
    end else if (saturation[SW-2:0] > ONE) begin
      sat_clip = ONE;
    end else begin
      sat_clip = saturation[SW-2:0];
    end
    sf_prod = (2*CW)'(sat_d[HS-1]) * (2*CW)'(frac);
    sg_prod = (2*CW)'(sat_d[HS-1]) * (2*CW)'(ONE - CW'(frac));
    p_prod  = (2*CW)'(val_d[HS-1]) * (2*CW)'(ONE - sat_d[HS-1]);
    q_prod  = (2*CW)'(val4) * (2*CW)'(ONE - sf4);
    t_prod  = (2*CW)'(val4) * (2*CW)'(ONE - sg4);
  end

  always_comb begin
    red_next   = '0;
    green_next = '0;
    blue_next  = '0;
    if (grey5) begin
      red_next   = val5;
      green_next = val5;
      blue_next  = val5;
    end else begin
      case (8'(sec5))
        8'd0: begin
          red_next = val5; green_next = t5; blue_next = p5;
        end
        8'd1: begin
          red_next = q5; green_next = val5; blue_next = p5;
        end
        8'd2: begin
          red_next = p5; green_next = val5; blue_next = t5;
        end
        8'd3: begin
          red_next = p5; green_next = q5; blue_next = val5;
        end
        8'd4: begin
          red_next = t5; green_next = p5; blue_next = val5;
        end
        8'd5: begin
          red_next = val5; green_next = p5; blue_next = q5;
        end
        default: begin
          red_next = '0; green_next = '0; blue_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      sat_d[0] <= sat_clip;
      val_d[0] <= brightness;
    end
    for (int i = 1; i < HS; i++) begin
      if (load[i]) begin
        sat_d[i] <= sat_d[i-1];
        val_d[i] <= val_d[i-1];
      end
    end
    if (load[HS]) begin
      sf4   <= sf_prod[CF +: CW];
      sg4   <= sg_prod[CF +: CW];
      p4    <= p_prod[CF +: CW];
      val4  <= val_d[HS-1];
      grey4 <= sat_d[HS-1] == '0;
      sec4  <= sector;
    end
    if (load[HS+1]) begin
      q5    <= q_prod[CF +: CW];
      t5    <= t_prod[CF +: CW];
      p5    <= p4;
      val5  <= val4;
      grey5 <= grey4;
      sec5  <= sec4;
    end
    if (load[HS+2]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

### hdl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV to RGB color conversion, one pixel per clock while not stalled.
// ----------------------------------------------------------------------------
// The converter takes one HSV request per clock while hsv_ready is high and
// passes it through seven register stages (two divide-by-60 steps on
// the hue, each a reciprocal multiply plus a correction stage, then two
// multiply stages for p, q and t, then the channel select) to its RGB result.
// A stalled output holds its result while empty stages upstream keep
// filling, so input ready drops only when all seven stages are occupied.
// Hue is unsigned degrees with HUE_FRAC_BITS fraction bits (exactly 360
// wraps to 0, sectors above 5 give black at nonzero saturation); saturation is
// signed, clipped to 0..1.0; brightness and outputs are Q1.CHANNEL_FRAC_BITS.
module hsv_to_rgb_converter #(
  parameter int CHANNEL_FRAC_BITS = hsv2rgb_pkg::CHANNEL_FRAC_BITS_DEF,
  parameter int HUE_FRAC_BITS     = hsv2rgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                hsv_valid,
  output logic                                hsv_ready,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue,
  input  logic signed [CHANNEL_FRAC_BITS+1:0] saturation,
  input  logic [CHANNEL_FRAC_BITS:0]          brightness,
  output logic                                rgb_valid,
  input  logic                                rgb_ready,
  output logic [CHANNEL_FRAC_BITS:0]          red,
  output logic [CHANNEL_FRAC_BITS:0]          green,
  output logic [CHANNEL_FRAC_BITS:0]          blue
);

  localparam int SECW = hsv2rgb_pkg::HUE_W - HUE_FRAC_BITS - 5;
  localparam int HS   = hsv2rgb_pkg::HUE_STAGES;

  hsv2rgb_pkg::stage_vec_t load;
  logic [SECW-1:0]              sector;
  logic [CHANNEL_FRAC_BITS-1:0] frac;

  hsv2rgb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_ready (hsv_ready),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .load      (load)
  );

  hsv2rgb_hue #(
    .CHANNEL_FRAC_BITS (CHANNEL_FRAC_BITS),
    .HUE_FRAC_BITS     (HUE_FRAC_BITS)
  ) u_hue (
    .clk    (clk),
    .load   (load[HS-1:0]),
    .hue    (hue),
    .sector (sector),
    .frac   (frac)
  );

  hsv2rgb_mix #(
    .CHANNEL_FRAC_BITS (CHANNEL_FRAC_BITS),
    .HUE_FRAC_BITS     (HUE_FRAC_BITS)
  ) u_mix (
    .clk        (clk),
    .load       (load),
    .saturation (saturation),
    .brightness (brightness),
    .sector     (sector),
    .frac       (frac),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

endmodule
